/* rtl/core/kvfp_pkg.sv */
package kvfp_pkg;

    // Default sizes of the key and value buffers (one slot stays unused)
    localparam int KEY_CHARS_DEF   = 16;
    localparam int VALUE_CHARS_DEF = 16;

    // Character codes
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_X     = 8'h78;
    localparam logic [7:0] CHR_O     = 8'h4F;
    localparam logic [7:0] CHR_N     = 8'h4E;

    // Special keys, first character in the low byte
    localparam logic [63:0] KEY_CHECKSUM = 64'h6D75_736B_6365_6843;
    localparam logic [23:0] KEY_PID      = 24'h44_4950;

    // CR plus LF that closed the line before a PID line
    localparam logic [7:0] PID_SUM_BASE = 8'h17;

    // Output stream layout
    localparam int TDATA_W         = 296;
    localparam int TUSER_W         = 3;
    localparam int VALUE_LSB       = 128;
    localparam int NUMBER_LSB      = 256;
    localparam int LINES_LSB       = 288;
    localparam int USER_IS_ON      = 0;
    localparam int USER_LINE_GOOD  = 1;
    localparam int USER_FRAME_GOOD = 2;

    typedef struct packed {
        logic stop;
        logic neg;
        logic hex;
    } num_mode_t;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

/* rtl/core/key_value_frame_parser_unit.sv */
// Path: an accepted byte goes into the input register and is parsed into the result
// register once that register is free; a line result then shows on the master side.
// Throughput: one byte per cycle, sustained while results are taken; a waiting result
// stalls the byte input register only, set by the single result register.
// Reset: rst_n is asynchronous, active low; it empties both registers and clears key,
// value, line, number and frame state to zero.
module key_value_frame_parser_unit
    import kvfp_pkg::*;
#(
    parameter int KEY_CHARS   = KEY_CHARS_DEF,
    parameter int VALUE_CHARS = VALUE_CHARS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // byte_in
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // key_first_half, key_second_half, value_first_half, value_second_half,
    // number_value, lines_seen
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [TUSER_W-1:0] m_axis_tuser,   // is_on, line_good, frame_good
    output logic               m_axis_tlast    // frame_done
);

    localparam int KW = $clog2(KEY_CHARS);
    localparam int VW = $clog2(VALUE_CHARS);
    localparam logic [KW-1:0] KEY_MAX   = KW'(KEY_CHARS - 1);
    localparam logic [VW-1:0] VALUE_MAX = VW'(VALUE_CHARS - 1);

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // Parser state
    logic [7:0]    key_store_reg   [KEY_CHARS];
    logic [7:0]    key_store_next  [KEY_CHARS];
    logic [7:0]    value_store_reg [VALUE_CHARS];
    logic [7:0]    value_store_next[VALUE_CHARS];
    logic [KW-1:0] key_count_reg, key_count_next;
    logic [VW-1:0] value_pos_reg, value_pos_next;
    logic          after_tab_reg, after_tab_next;
    logic          too_long_reg, too_long_next;
    logic [7:0]    line_len_reg, line_len_next;
    logic [7:0]    line_sum_reg, line_sum_next;
    logic [7:0]    frame_sum_reg, frame_sum_next;
    logic [7:0]    good_lines_reg, good_lines_next;
    logic [31:0]   num_acc_reg, num_acc_next;
    num_mode_t     num_mode_reg, num_mode_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0] out_data_reg, out_data_next;
    logic [TUSER_W-1:0] out_user_reg, out_user_next;
    logic               out_last_reg, out_last_next;

    logic       fire;
    logic       s_accept;
    logic [7:0] b;

    // Value store after taking the current byte as a value character
    logic [7:0]    vc_store[VALUE_CHARS];
    logic [VW-1:0] vc_pos;
    logic [31:0]   vc_acc;
    num_mode_t     vc_mode;
    logic          vc_too_long;

    logic [127:0] key_flat;
    logic [127:0] val_cur_flat;
    logic [127:0] val_vc_flat;

    logic cks;
    logic pid;
    logic line_good_cur;

    // Handshake: hold the byte while the result register is occupied
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign b             = in_byte_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // Flatten stores into zero-padded 16-byte words
    for (genvar g = 0; g < 16; g++) begin : g_flat
        if (g < KEY_CHARS) begin : g_key
            assign key_flat[8*g +: 8] = key_store_reg[g];
        end
        else begin : g_key_pad
            assign key_flat[8*g +: 8] = 8'd0;
        end
        if (g < VALUE_CHARS) begin : g_val
            assign val_cur_flat[8*g +: 8] = value_store_reg[g];
            assign val_vc_flat[8*g +: 8]  = vc_store[g];
        end
        else begin : g_val_pad
            assign val_cur_flat[8*g +: 8] = 8'd0;
            assign val_vc_flat[8*g +: 8]  = 8'd0;
        end
    end

    // Special line detection
    assign cks = after_tab_reg && (5'(key_count_reg) == 5'd8) && (line_len_reg == 8'd9)
              && (value_pos_reg == '0) && (key_flat[63:0] == KEY_CHECKSUM);
    assign pid = !after_tab_reg && (line_len_reg == 8'd3) && (5'(key_count_reg) == 5'd3)
              && (key_flat[23:0] == KEY_PID);
    assign line_good_cur = after_tab_reg && (key_count_reg != '0) && (value_pos_reg != '0)
                        && !too_long_reg;

    // Append the byte to the value and advance the number conversion
    always_comb
    begin
        logic [4:0]  hd;
        logic [31:0] times_ten;
        hd          = hex_digit(b);
        times_ten   = (num_acc_reg << 3) + (num_acc_reg << 1);
        vc_store    = value_store_reg;
        vc_pos      = value_pos_reg;
        vc_acc      = num_acc_reg;
        vc_mode     = num_mode_reg;
        vc_too_long = too_long_reg;
        if (value_pos_reg < VALUE_MAX)
        begin
            vc_store[value_pos_reg] = b;
            vc_pos = value_pos_reg + 1'b1;
            if (!num_mode_reg.stop)
            begin
                if (num_mode_reg.hex)
                begin
                    if (!hd[4])
                    begin
                        vc_mode.stop = 1'b1;
                    end
                    else
                    begin
                        vc_acc = {num_acc_reg[27:0], hd[3:0]};
                    end
                end
                else if (value_pos_reg == '0 && b == CHR_MINUS)
                begin
                    vc_mode.neg = 1'b1;
                end
                else if (value_pos_reg == '0 && b == CHR_PLUS)
                begin
                    vc_mode = num_mode_reg;
                end
                else if (value_pos_reg == VW'(1) && b == CHR_X
                         && value_store_reg[0] == CHR_ZERO)
                begin
                    vc_mode.hex = 1'b1;
                    vc_acc      = 32'd0;
                end
                else if (b >= CHR_ZERO && b <= CHR_NINE)
                begin
                    vc_acc = times_ten + {24'd0, b - CHR_ZERO};
                end
                else
                begin
                    vc_mode.stop = 1'b1;
                end
            end
        end
        else
        begin
            vc_too_long = 1'b1;
        end
    end

    // Next state and result for one byte
    always_comb
    begin
        logic [127:0]  res_val;
        logic [VW-1:0] res_pos;
        logic [31:0]   res_acc;
        num_mode_t     res_mode;
        logic [31:0]   res_number;
        logic          res_is_on;
        logic [7:0]    len_inc;

        in_valid_next    = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        key_store_next   = key_store_reg;
        value_store_next = value_store_reg;
        key_count_next   = key_count_reg;
        value_pos_next   = value_pos_reg;
        after_tab_next   = after_tab_reg;
        too_long_next    = too_long_reg;
        line_len_next    = line_len_reg;
        line_sum_next    = line_sum_reg;
        frame_sum_next   = frame_sum_reg;
        good_lines_next  = good_lines_reg;
        num_acc_next     = num_acc_reg;
        num_mode_next    = num_mode_reg;
        out_valid_next   = m_axis_tready ? 1'b0 : out_valid_reg;
        out_data_next    = out_data_reg;
        out_user_next    = out_user_reg;
        out_last_next    = out_last_reg;

        len_inc = (line_len_reg != 8'hFF) ? line_len_reg + 8'd1 : line_len_reg;

        // Result fields: checksum line shows the value with its byte taken in
        res_val    = cks ? val_vc_flat : val_cur_flat;
        res_pos    = cks ? vc_pos : value_pos_reg;
        res_acc    = cks ? vc_acc : num_acc_reg;
        res_mode   = cks ? vc_mode : num_mode_reg;
        res_number = res_mode.neg ? (32'd0 - res_acc) : res_acc;
        res_is_on  = (res_pos == VW'(2)) && (res_val[7:0] == CHR_O)
                  && (res_val[15:8] == CHR_N);

        if (fire)
        begin
            frame_sum_next = frame_sum_reg + b;
            if (cks)
            begin
                // Close the frame on the checksum byte
                line_len_next    = len_inc;
                line_sum_next    = line_sum_reg + b;
                value_store_next = vc_store;
                value_pos_next   = vc_pos;
                num_acc_next     = vc_acc;
                num_mode_next    = vc_mode;
                too_long_next    = vc_too_long;
                out_valid_next   = 1'b1;
                out_last_next    = 1'b1;
                out_user_next    = '0;
                out_user_next[USER_IS_ON]      = res_is_on;
                out_user_next[USER_FRAME_GOOD] = (frame_sum_next == 8'd0)
                                              && (good_lines_reg != 8'd0);
                out_data_next = {good_lines_reg, res_number, res_val, key_flat};
            end
            else if (b == CHR_CR)
            begin
                // Drop carriage return
                out_valid_next = m_axis_tready ? 1'b0 : out_valid_reg;
            end
            else if (b == CHR_LF)
            begin
                // End the line: emit the result and clear line state
                if (line_good_cur && good_lines_reg != 8'hFF)
                begin
                    good_lines_next = good_lines_reg + 8'd1;
                end
                out_valid_next = 1'b1;
                out_last_next  = 1'b0;
                out_user_next  = '0;
                out_user_next[USER_IS_ON]     = res_is_on;
                out_user_next[USER_LINE_GOOD] = line_good_cur;
                out_data_next = {good_lines_next, res_number, res_val, key_flat};
                for (int i = 0; i < KEY_CHARS; i++)
                begin
                    key_store_next[i] = 8'd0;
                end
                for (int i = 0; i < VALUE_CHARS; i++)
                begin
                    value_store_next[i] = 8'd0;
                end
                key_count_next = '0;
                value_pos_next = '0;
                after_tab_next = 1'b0;
                too_long_next  = 1'b0;
                line_len_next  = 8'd0;
                line_sum_next  = 8'd0;
                num_acc_next   = 32'd0;
                num_mode_next  = '0;
            end
            else
            begin
                line_len_next = len_inc;
                line_sum_next = line_sum_reg + b;
                if (b == CHR_TAB)
                begin
                    // Restart the frame on a PID line; each tab restarts the value
                    if (pid)
                    begin
                        frame_sum_next  = PID_SUM_BASE + line_sum_reg + b;
                        good_lines_next = 8'd0;
                    end
                    after_tab_next = 1'b1;
                    for (int i = 0; i < VALUE_CHARS; i++)
                    begin
                        value_store_next[i] = 8'd0;
                    end
                    value_pos_next = '0;
                    num_acc_next   = 32'd0;
                    num_mode_next  = '0;
                end
                else if (after_tab_reg)
                begin
                    value_store_next = vc_store;
                    value_pos_next   = vc_pos;
                    num_acc_next     = vc_acc;
                    num_mode_next    = vc_mode;
                    too_long_next    = vc_too_long;
                end
                else if (key_count_reg < KEY_MAX)
                begin
                    key_store_next[key_count_reg] = b;
                    key_count_next = key_count_reg + 1'b1;
                end
                else
                begin
                    too_long_next = 1'b1;
                end
            end
        end
    end

    // Control and parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < KEY_CHARS; i++)
            begin
                key_store_reg[i] <= 8'd0;
            end
            for (int i = 0; i < VALUE_CHARS; i++)
            begin
                value_store_reg[i] <= 8'd0;
            end
            key_count_reg  <= '0;
            value_pos_reg  <= '0;
            after_tab_reg  <= 1'b0;
            too_long_reg   <= 1'b0;
            line_len_reg   <= 8'd0;
            line_sum_reg   <= 8'd0;
            frame_sum_reg  <= 8'd0;
            good_lines_reg <= 8'd0;
            num_acc_reg    <= 32'd0;
            num_mode_reg   <= '0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            key_store_reg   <= key_store_next;
            value_store_reg <= value_store_next;
            key_count_reg   <= key_count_next;
            value_pos_reg   <= value_pos_next;
            after_tab_reg   <= after_tab_next;
            too_long_reg    <= too_long_next;
            line_len_reg    <= line_len_next;
            line_sum_reg    <= line_sum_next;
            frame_sum_reg   <= frame_sum_next;
            good_lines_reg  <= good_lines_next;
            num_acc_reg     <= num_acc_next;
            num_mode_reg    <= num_mode_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

endmodule

/* rtl/core/kvfp_checker.sv */
module kvfp_checker
    import kvfp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic [TUSER_W-1:0] m_axis_tuser,
    input logic               m_axis_tlast
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Frame good only on a frame-closing result
    a_frame_good_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[USER_FRAME_GOOD] |-> m_axis_tlast)
        else $error("frame good without frame done");

    // A checksum result is never a good line
    a_last_not_good: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser[USER_LINE_GOOD])
        else $error("line good on checksum result");

    // ON flag matches the value text
    a_on_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[USER_IS_ON]
        |-> m_axis_tdata[VALUE_LSB +: 128] == {112'd0, CHR_N, CHR_O})
        else $error("is_on with value other than ON");

    // A good line is counted
    a_good_counted: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[USER_LINE_GOOD] |-> m_axis_tdata[LINES_LSB +: 8] != 8'd0)
        else $error("good line not counted");

endmodule

bind key_value_frame_parser_unit kvfp_checker u_kvfp_checker (.*);
